[rtl/chji_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Hermite joint interpolator package
// Widths, stage records and rounding constants shared by the datapath.
// ----------------------------------------------------------------------------
package chji_pkg;

    localparam int TIME_W       = 32;
    localparam int POS_W        = 32;
    localparam int TIME_FRAC    = 16;
    localparam int S_FRAC       = 30;
    localparam int S_W          = S_FRAC + 1;
    localparam int DIV_STEPS    = S_FRAC;
    localparam int IN_W         = 2 * TIME_W + 4 * POS_W;
    localparam int PROD_W       = POS_W + TIME_W + 1;
    localparam int B_W          = PROD_W - TIME_FRAC - 1;
    localparam int DP_W         = POS_W + 1;
    localparam int C_W          = B_W + 3;
    localparam int D_W          = C_W + 1;
    localparam int ACC_W        = D_W + 4;
    localparam int SPLIT        = ACC_W / 2;
    localparam int PL_W         = SPLIT + S_W;
    localparam int PH_W         = ACC_W - SPLIT + S_W + 1;
    localparam int FULL_W       = ACC_W + S_W + 1;
    localparam int HORNER_STEPS = 3;
    localparam int COEF_STG     = 4;
    localparam int NSTG         = DIV_STEPS + 3 * HORNER_STEPS + 2;

    localparam logic [S_W-1:0] S_ONE = {1'b1, {S_FRAC{1'b0}}};

    localparam logic signed [PROD_W-1:0] HALF_T    = PROD_W'(1) << (TIME_FRAC - 1);
    localparam logic signed [PROD_W-1:0] HALF_T_M1 = HALF_T - PROD_W'(1);
    localparam logic signed [FULL_W-1:0] HALF_S    = FULL_W'(1) << (S_FRAC - 1);
    localparam logic signed [FULL_W-1:0] HALF_S_M1 = HALF_S - FULL_W'(1);

    localparam logic signed [ACC_W-1:0] POS_MAX =
        {{(ACC_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] POS_MIN =
        {{(ACC_W - POS_W + 1){1'b1}}, {(POS_W - 1){1'b0}}};

    typedef struct packed {
        logic [TIME_W-1:0]        seg_time;
        logic [TIME_W-1:0]        seg_length;
        logic signed [POS_W-1:0]  start_pos;
        logic signed [POS_W-1:0]  end_pos;
        logic signed [POS_W-1:0]  start_vel;
        logic signed [POS_W-1:0]  end_vel;
    } in_t;

    typedef struct packed {
        logic                 zero;
        logic                 sat;
        logic [TIME_W-1:0]    len;
        logic [TIME_W-1:0]    rem;
        logic [DIV_STEPS-1:0] quo;
    } dv_t;

    typedef struct packed {
        logic signed [POS_W-1:0] p0;
        logic signed [POS_W-1:0] p1;
        logic signed [POS_W-1:0] v0;
        logic signed [POS_W-1:0] v1;
    } pv_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod0;
        logic signed [PROD_W-1:0] prod1;
        logic signed [DP_W-1:0]   dp;
        logic signed [POS_W-1:0]  p0;
    } mul_t;

    typedef struct packed {
        logic signed [B_W-1:0]   b;
        logic signed [B_W-1:0]   v1t;
        logic signed [DP_W-1:0]  dp;
        logic signed [POS_W-1:0] p0;
    } rnd_t;

    typedef struct packed {
        logic signed [B_W-1:0]   b;
        logic signed [C_W-1:0]   c;
        logic signed [DP_W-1:0]  dp;
        logic signed [POS_W-1:0] p0;
    } cc_t;

    typedef struct packed {
        logic signed [POS_W-1:0] p0;
        logic signed [B_W-1:0]   b;
        logic signed [C_W-1:0]   c;
        logic signed [D_W-1:0]   d;
    } co_t;

    typedef struct packed {
        logic                                 zero;
        logic [S_W-1:0]                       s;
        logic [HORNER_STEPS-1:0][ACC_W-1:0]   add;
        logic signed [ACC_W-1:0]              x;
    } hacc_t;

    typedef struct packed {
        logic                                 zero;
        logic [S_W-1:0]                       s;
        logic [HORNER_STEPS-1:0][ACC_W-1:0]   add;
        logic                                 xneg;
        logic [PL_W-1:0]                      pl;
        logic signed [PH_W-1:0]               ph;
    } hmul_t;

    typedef struct packed {
        logic                                 zero;
        logic [S_W-1:0]                       s;
        logic [HORNER_STEPS-1:0][ACC_W-1:0]   add;
        logic signed [FULL_W-1:0]             full;
    } hsum_t;

endpackage
`default_nettype wire

[rtl/cubic_hermite_joint_interp_unit.sv]
`default_nettype none
// Throughput: one word per cycle; the pipeline moves whenever the output register is free.
// The depth is set by the 30-stage one-bit-per-stage divider for s = t/T and by three
// Horner steps of three stages each (split multiply, rounding sum, add).
// Reset clears the valid bits and the skid valid flag; datapath registers are not reset.
// ----------------------------------------------------------------------------
// Cubic Hermite joint interpolator
// Streams one joint sample per word: normalizes the segment time, builds the
// Hermite coefficients and evaluates the cubic in fixed point with saturation.
// ----------------------------------------------------------------------------
module cubic_hermite_joint_interp_unit (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // seg_time, seg_length, start_pos, end_pos, start_vel, end_vel (lowest bits first)
    input  wire [chji_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // position
    output logic [chji_pkg::POS_W-1:0]      m_axis_tdata,
    // zero_length
    output logic [0:0]                      m_axis_tuser
);

    localparam int TIME_W    = chji_pkg::TIME_W;
    localparam int POS_W     = chji_pkg::POS_W;
    localparam int DIV_STEPS = chji_pkg::DIV_STEPS;
    localparam int COEF_STG  = chji_pkg::COEF_STG;
    localparam int HSTEPS    = chji_pkg::HORNER_STEPS;
    localparam int NSTG      = chji_pkg::NSTG;
    localparam int ACC_W     = chji_pkg::ACC_W;
    localparam int C_W       = chji_pkg::C_W;
    localparam int D_W       = chji_pkg::D_W;
    localparam int B_W       = chji_pkg::B_W;
    localparam int PL_W      = chji_pkg::PL_W;
    localparam int FULL_W    = chji_pkg::FULL_W;
    localparam int SPLIT     = chji_pkg::SPLIT;

    chji_pkg::in_t   s_in;
    chji_pkg::in_t   src;
    chji_pkg::in_t   skid_reg;
    chji_pkg::in_t   skid_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    logic            s_accept;
    logic            pipe_en;
    logic            src_valid;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    chji_pkg::dv_t   dv_reg  [0:DIV_STEPS];
    chji_pkg::dv_t   dv_next [0:DIV_STEPS];
    logic [TIME_W:0] r2      [1:DIV_STEPS];
    logic            ge      [1:DIV_STEPS];

    chji_pkg::pv_t   pv_reg;
    chji_pkg::pv_t   pv_next;
    chji_pkg::mul_t  mul_reg;
    chji_pkg::mul_t  mul_next;
    chji_pkg::rnd_t  rnd_reg;
    chji_pkg::rnd_t  rnd_next;
    chji_pkg::cc_t   cc_reg;
    chji_pkg::cc_t   cc_next;
    chji_pkg::co_t   co_reg  [COEF_STG:DIV_STEPS];
    chji_pkg::co_t   co_next [COEF_STG:DIV_STEPS];

    logic signed [chji_pkg::PROD_W-1:0] rnd_sum0;
    logic signed [chji_pkg::PROD_W-1:0] rnd_sum1;
    logic signed [C_W-1:0]              dp_c;

    chji_pkg::hacc_t hsrc;
    chji_pkg::hacc_t hin     [0:HSTEPS-1];
    chji_pkg::hmul_t hm_reg  [0:HSTEPS-1];
    chji_pkg::hmul_t hm_next [0:HSTEPS-1];
    chji_pkg::hsum_t hs_reg  [0:HSTEPS-1];
    chji_pkg::hsum_t hs_next [0:HSTEPS-1];
    chji_pkg::hacc_t ha_reg  [0:HSTEPS-1];
    chji_pkg::hacc_t ha_next [0:HSTEPS-1];

    logic signed [ACC_W-1:0] acc;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic                    zero_reg;
    logic                    zero_next;

    assign s_in.seg_time   = s_axis_tdata[0 +: TIME_W];
    assign s_in.seg_length = s_axis_tdata[TIME_W +: TIME_W];
    assign s_in.start_pos  = s_axis_tdata[2*TIME_W +: POS_W];
    assign s_in.end_pos    = s_axis_tdata[2*TIME_W + POS_W +: POS_W];
    assign s_in.start_vel  = s_axis_tdata[2*TIME_W + 2*POS_W +: POS_W];
    assign s_in.end_vel    = s_axis_tdata[2*TIME_W + 3*POS_W +: POS_W];

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = pos_reg;
    assign m_axis_tuser  = zero_reg;

    // Input skid word and pipeline advance.
    always_comb begin
        s_accept  = s_axis_tvalid && s_axis_tready;
        pipe_en   = m_axis_tready || !vld_reg[NSTG-1];
        src_valid = skid_valid_reg || s_accept;
        src       = skid_valid_reg ? skid_reg : s_in;
        if (pipe_en) begin
            skid_valid_next = 1'b0;
        end else begin
            skid_valid_next = skid_valid_reg || s_accept;
        end
        skid_next = (!pipe_en && s_accept) ? s_in : skid_reg;
        vld_next  = {vld_reg[NSTG-2:0], src_valid};
    end

    // Restoring divider, one quotient bit per stage.
    always_comb begin
        dv_next[0].zero = (src.seg_length == '0);
        dv_next[0].sat  = (src.seg_time >= src.seg_length);
        dv_next[0].len  = src.seg_length;
        dv_next[0].rem  = src.seg_time;
        dv_next[0].quo  = '0;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            r2[k]          = {dv_reg[k-1].rem, 1'b0};
            ge[k]          = (r2[k] >= {1'b0, dv_reg[k-1].len});
            dv_next[k]     = dv_reg[k-1];
            dv_next[k].rem = ge[k] ? TIME_W'(r2[k] - {1'b0, dv_reg[k-1].len})
                                   : r2[k][TIME_W-1:0];
            dv_next[k].quo = {dv_reg[k-1].quo[DIV_STEPS-2:0], ge[k]};
        end
    end

    // Coefficients: velocity scaling, rounding, then c and d.
    always_comb begin
        pv_next.p0 = src.start_pos;
        pv_next.p1 = src.end_pos;
        pv_next.v0 = src.start_vel;
        pv_next.v1 = src.end_vel;

        mul_next.prod0 = chji_pkg::PROD_W'(pv_reg.v0)
                       * chji_pkg::PROD_W'($signed({1'b0, dv_reg[0].len}));
        mul_next.prod1 = chji_pkg::PROD_W'(pv_reg.v1)
                       * chji_pkg::PROD_W'($signed({1'b0, dv_reg[0].len}));
        mul_next.dp    = chji_pkg::DP_W'(pv_reg.p1) - chji_pkg::DP_W'(pv_reg.p0);
        mul_next.p0    = pv_reg.p0;

        rnd_sum0 = mul_reg.prod0 + (mul_reg.prod0[chji_pkg::PROD_W-1] ?
                                    chji_pkg::HALF_T_M1 : chji_pkg::HALF_T);
        rnd_sum1 = mul_reg.prod1 + (mul_reg.prod1[chji_pkg::PROD_W-1] ?
                                    chji_pkg::HALF_T_M1 : chji_pkg::HALF_T);
        rnd_next.b   = B_W'(rnd_sum0 >>> chji_pkg::TIME_FRAC);
        rnd_next.v1t = B_W'(rnd_sum1 >>> chji_pkg::TIME_FRAC);
        rnd_next.dp  = mul_reg.dp;
        rnd_next.p0  = mul_reg.p0;

        dp_c       = C_W'(rnd_reg.dp);
        cc_next.b  = rnd_reg.b;
        cc_next.c  = (dp_c <<< 1) + dp_c - (C_W'(rnd_reg.b) <<< 1) - C_W'(rnd_reg.v1t);
        cc_next.dp = rnd_reg.dp;
        cc_next.p0 = rnd_reg.p0;

        co_next[COEF_STG].p0 = cc_reg.p0;
        co_next[COEF_STG].b  = cc_reg.b;
        co_next[COEF_STG].c  = cc_reg.c;
        co_next[COEF_STG].d  = D_W'(cc_reg.dp) - D_W'(cc_reg.b) - D_W'(cc_reg.c);
        for (int k = COEF_STG + 1; k <= DIV_STEPS; k++) begin
            co_next[k] = co_reg[k-1];
        end
    end

    // Horner evaluation: x*s split in two partial products, rounded, then added.
    always_comb begin
        hsrc.zero   = dv_reg[DIV_STEPS].zero;
        hsrc.s      = dv_reg[DIV_STEPS].sat ? chji_pkg::S_ONE : {1'b0, dv_reg[DIV_STEPS].quo};
        hsrc.add[0] = ACC_W'(co_reg[DIV_STEPS].c);
        hsrc.add[1] = ACC_W'(co_reg[DIV_STEPS].b);
        hsrc.add[2] = ACC_W'(co_reg[DIV_STEPS].p0);
        hsrc.x      = ACC_W'(co_reg[DIV_STEPS].d);

        hin[0] = hsrc;
        for (int j = 1; j < HSTEPS; j++) begin
            hin[j] = ha_reg[j-1];
        end

        for (int j = 0; j < HSTEPS; j++) begin
            hm_next[j].zero = hin[j].zero;
            hm_next[j].s    = hin[j].s;
            hm_next[j].add  = hin[j].add;
            hm_next[j].xneg = hin[j].x[ACC_W-1];
            hm_next[j].pl   = PL_W'(hin[j].x[SPLIT-1:0]) * PL_W'(hin[j].s);
            hm_next[j].ph   = chji_pkg::PH_W'($signed(hin[j].x[ACC_W-1:SPLIT]))
                            * chji_pkg::PH_W'($signed({1'b0, hin[j].s}));

            hs_next[j].zero = hm_reg[j].zero;
            hs_next[j].s    = hm_reg[j].s;
            hs_next[j].add  = hm_reg[j].add;
            hs_next[j].full = (FULL_W'(hm_reg[j].ph) <<< SPLIT)
                            + $signed({{(FULL_W - PL_W){1'b0}}, hm_reg[j].pl})
                            + (hm_reg[j].xneg ? chji_pkg::HALF_S_M1 : chji_pkg::HALF_S);

            ha_next[j].zero = hs_reg[j].zero;
            ha_next[j].s    = hs_reg[j].s;
            ha_next[j].add  = hs_reg[j].add;
            ha_next[j].x    = ACC_W'(hs_reg[j].full >>> chji_pkg::S_FRAC)
                            + $signed(hs_reg[j].add[j]);
        end
    end

    // Output saturation.
    always_comb begin
        acc       = ha_reg[HSTEPS-1].x;
        zero_next = ha_reg[HSTEPS-1].zero;
        if (acc > chji_pkg::POS_MAX) begin
            pos_next = POS_W'(chji_pkg::POS_MAX);
        end else if (acc < chji_pkg::POS_MIN) begin
            pos_next = POS_W'(chji_pkg::POS_MIN);
        end else begin
            pos_next = POS_W'(acc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            vld_reg        <= '0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            if (pipe_en) begin
                vld_reg <= vld_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        skid_reg <= skid_next;
        if (pipe_en) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                dv_reg[k] <= dv_next[k];
            end
            pv_reg  <= pv_next;
            mul_reg <= mul_next;
            rnd_reg <= rnd_next;
            cc_reg  <= cc_next;
            for (int k = COEF_STG; k <= DIV_STEPS; k++) begin
                co_reg[k] <= co_next[k];
            end
            for (int j = 0; j < HSTEPS; j++) begin
                hm_reg[j] <= hm_next[j];
                hs_reg[j] <= hs_next[j];
                ha_reg[j] <= ha_next[j];
            end
            pos_reg  <= pos_next;
            zero_reg <= zero_next;
        end
    end

    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !pipe_en |=> skid_valid_reg)
        else $error("Skid word dropped while the pipeline was stalled.");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !pipe_en |=> skid_valid_reg)
        else $error("Word accepted during a stall was not captured.");

    a_zero_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] && dv_reg[0].zero |-> dv_reg[0].sat)
        else $error("Zero-length segment did not force a full-scale time.");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[DIV_STEPS] && !dv_reg[DIV_STEPS].sat |->
            dv_reg[DIV_STEPS].rem < dv_reg[DIV_STEPS].len)
        else $error("Divider remainder not below the divisor.");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_en && vld_reg[NSTG-2] |=> m_axis_tvalid)
        else $error("Word lost on its way into the output register.");

endmodule
`default_nettype wire

[tb/sv/cubic_hermite_joint_interp_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cubic Hermite joint interpolator testbench
// Streams directed and random joint samples into the interpolator and checks
// every result word against a fixed-point Hermite predictor. The run covers
// sender and receiver idling, a long receiver hold-off and drained pauses.
// ----------------------------------------------------------------------------
module cubic_hermite_joint_interp_unit_tb;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 10;
    localparam int PHASE_ITEMS  = 550;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HERMITE_S_FRAC = 30;
    localparam int HERMITE_T_FRAC = 16;

    typedef struct packed {
        logic [chji_pkg::POS_W-1:0] position;
        logic                       zero_length;
    } sample_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // seg_time, seg_length, start_pos, end_pos, start_vel, end_vel (lowest bits first)
    logic [chji_pkg::IN_W-1:0]    s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // position
    logic [chji_pkg::POS_W-1:0]   m_axis_tdata;
    // zero_length
    logic [0:0]                   m_axis_tuser;

    chji_pkg::in_t pending_samples[$];
    sample_t       expected_positions[$];
    chji_pkg::in_t offered_sample;
    int unsigned   send_idle_pct = 9;
    int unsigned   recv_idle_pct = 52;
    logic          long_hold = 1'b0;
    int unsigned   hold_count = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;

    cubic_hermite_joint_interp_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic longint round_shift(longint x, int sh);
        longint unsigned mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (x < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint scale_by_s(longint x, longint unsigned s);
        longint unsigned mag;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned prod;
        mag = (x < 0) ? -x : x;
        hi = mag >> HERMITE_S_FRAC;
        lo = mag & ((64'd1 << HERMITE_S_FRAC) - 1);
        prod = hi * s + ((lo * s + (64'd1 << (HERMITE_S_FRAC - 1))) >> HERMITE_S_FRAC);
        return (x < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic sample_t predict_position(chji_pkg::in_t it);
        longint unsigned t_q;
        longint unsigned len_q;
        longint unsigned s;
        longint p0, p1, v0, v1, b, v1t, dp, c, d, acc;
        sample_t r;
        t_q = it.seg_time;
        len_q = it.seg_length;
        p0 = it.start_pos;
        p1 = it.end_pos;
        v0 = it.start_vel;
        v1 = it.end_vel;
        if (len_q == 0) begin
            r.position = it.end_pos;
            r.zero_length = 1'b1;
            return r;
        end
        if (t_q >= len_q) begin
            s = 64'd1 << HERMITE_S_FRAC;
        end else begin
            s = (t_q << HERMITE_S_FRAC) / len_q;
        end
        b = round_shift(v0 * longint'(len_q), HERMITE_T_FRAC);
        v1t = round_shift(v1 * longint'(len_q), HERMITE_T_FRAC);
        dp = p1 - p0;
        c = 3 * dp - 2 * b - v1t;
        d = dp - b - c;
        acc = c + scale_by_s(d, s);
        acc = b + scale_by_s(acc, s);
        acc = p0 + scale_by_s(acc, s);
        if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
        end
        if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
        end
        r.position = acc[chji_pkg::POS_W-1:0];
        r.zero_length = 1'b0;
        return r;
    endfunction

    function automatic chji_pkg::in_t joint_sample(logic [31:0] t, logic [31:0] len,
                                                   logic [31:0] p0, logic [31:0] p1,
                                                   logic [31:0] v0, logic [31:0] v1);
        chji_pkg::in_t it;
        it.seg_time = t;
        it.seg_length = len;
        it.start_pos = p0;
        it.end_pos = p1;
        it.start_vel = v0;
        it.end_vel = v1;
        return it;
    endfunction

    // Most samples look like real trajectory segments; the rest use raw 32-bit fields.
    function automatic chji_pkg::in_t random_sample();
        chji_pkg::in_t it;
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 25) begin
            return joint_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        it.start_pos = $signed($urandom) >>> $urandom_range(12, 4);
        it.end_pos = $signed($urandom) >>> $urandom_range(12, 4);
        it.start_vel = $signed($urandom) >>> $urandom_range(14, 4);
        it.end_vel = $signed($urandom) >>> $urandom_range(14, 4);
        if (kind < 30) begin
            it.seg_length = '0;
        end else if (kind < 45) begin
            it.seg_length = $urandom_range(32'hFFFF_FFFF, 1);
        end else begin
            it.seg_length = $urandom_range(32'h0004_0000, 1);
        end
        if (kind < 40 || it.seg_length > 32'hFFFF_0000) begin
            it.seg_time = $urandom;
        end else if (kind < 55) begin
            it.seg_time = it.seg_length + $urandom_range(1000, 0);
        end else begin
            it.seg_time = $urandom_range(it.seg_length, 0);
        end
        return it;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                expected_positions.push_back(predict_position(offered_sample));
            end
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offered_sample = pending_samples.pop_front();
                s_axis_tdata <= {offered_sample.end_vel, offered_sample.start_vel,
                                 offered_sample.end_pos, offered_sample.start_pos,
                                 offered_sample.seg_length, offered_sample.seg_time};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
        end
    end

    always @(posedge aclk) begin
        sample_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(long_hold && hold_count < HOLD_CYCLES)
                             && $urandom_range(99) >= recv_idle_pct;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_positions.size() == 0) begin
                    $error("unexpected result word: position %h, zero_length %b",
                           m_axis_tdata, m_axis_tuser[0]);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_positions.pop_front();
                    if (m_axis_tdata !== want.position || m_axis_tuser[0] !== want.zero_length)
                    begin
                        mismatch_count <= mismatch_count + 1;
                    end
                    if (m_axis_tdata !== want.position) begin
                        $error("position: expected %h, actual %h", want.position, m_axis_tdata);
                    end
                    if (m_axis_tuser[0] !== want.zero_length) begin
                        $error("zero_length: expected %b, actual %b",
                               want.zero_length, m_axis_tuser[0]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int unsigned phase;
        int unsigned n;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero duration, time at and past the end, saturation both ways and rounding ties.
        pending_samples.push_back(joint_sample(32'h0001_0000, 32'h0, 32'h1234_5678,
                                               32'h7FFF_FFFF, 32'h0010_0000, 32'hFFF0_0000));
        pending_samples.push_back(joint_sample(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                                               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_samples.push_back(joint_sample(32'h0, 32'h0001_0000, 32'h0010_0000,
                                               32'h0020_0000, 32'h0, 32'h0));
        pending_samples.push_back(joint_sample(32'h0001_0000, 32'h0001_0000, 32'h0010_0000,
                                               32'h0020_0000, 32'h0008_0000, 32'hFFF8_0000));
        pending_samples.push_back(joint_sample(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFC0_0000,
                                               32'h0040_0000, 32'h0, 32'h0));
        pending_samples.push_back(joint_sample(32'h0000_8000, 32'h0001_0000, 32'hFFC0_0000,
                                               32'h0040_0000, 32'h0010_0000, 32'h0010_0000));
        pending_samples.push_back(joint_sample(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_samples.push_back(joint_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_samples.push_back(joint_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                                               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_samples.push_back(joint_sample(32'h0, 32'h1, 32'h8000_0000,
                                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_samples.push_back(joint_sample(32'h1, 32'h1, 32'h8000_0000,
                                               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        pending_samples.push_back(joint_sample(32'h1, 32'h3, 32'h0000_0001,
                                               32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFD));
        pending_samples.push_back(joint_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                                               32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_samples.push_back(joint_sample(32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_samples.push_back(joint_sample(32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_samples.push_back(joint_sample(32'h0000_4000, 32'h0000_8000, 32'h0,
                                               32'h0, 32'h0000_0001, 32'hFFFF_FFFF));
        pending_samples.push_back(joint_sample(32'h0000_4000, 32'h0000_8000, 32'h0,
                                               32'h0, 32'hFFFF_FFFF, 32'h0000_0003));
        pending_samples.push_back(joint_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct <= (phase == 0) ? 9 : (phase == 1) ? 52 : 0;
            recv_idle_pct <= (phase == 0) ? 52 : (phase == 1) ? 9 : 0;
            if (phase == 2) begin
                long_hold <= 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pending_samples.push_back(random_sample());
            end
            @(posedge aclk);
            while (pending_samples.size() != 0 || s_axis_tvalid || expected_positions.size() != 0)
            begin
                @(posedge aclk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
